// ===== rtl/tcpq_pkg.sv =====
// Shared constants and types for the two-class priority queue.
package tcpq_pkg;

	localparam int DATA_W        = 24;
	localparam int DEPTH_DEFAULT = 16;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef struct packed {
		logic accepted;
		logic pop_valid;
		logic from_urgent;
	} result_flags_t;

endpackage

// ===== rtl/two_class_priority_queue_top.sv =====
// Two-class strict-priority queue: urgent ring served before normal ring.
// The result appears in the cycle after the input transfer; the result register is the only stage.
// Throughput: one push or pop per cycle while out_stall is low, set by the single pass through the ring control.
// Read data is captured by the selected ring's memory port at the input transfer.
// Reset clears pointers, counts and result valid; ring contents are undefined until written.
module two_class_priority_queue_top #(
	parameter int DEPTH = tcpq_pkg::DEPTH_DEFAULT,
	localparam int PTR_W = $clog2(DEPTH),
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        operation,
	input  logic                        urgent,
	input  logic [tcpq_pkg::DATA_W-1:0] payload,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        accepted,
	output logic                        pop_valid,
	output logic                        out_urgent,
	output logic [tcpq_pkg::DATA_W-1:0] out_payload,
	output logic [CNT_W-1:0]            occupancy,
	output logic                        is_empty,
	output logic                        is_full
);

	logic                        urg_wr_en, urg_rd_en, norm_wr_en, norm_rd_en;
	logic [PTR_W-1:0]            urg_wr_addr, urg_rd_addr, norm_wr_addr, norm_rd_addr;
	logic [tcpq_pkg::DATA_W-1:0] urg_rd_data, norm_rd_data;
	tcpq_pkg::result_flags_t     flags;
	logic [CNT_W-1:0]            count;

	tcpq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.urgent       (urgent),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.urg_wr_en    (urg_wr_en),
		.urg_wr_addr  (urg_wr_addr),
		.urg_rd_en    (urg_rd_en),
		.urg_rd_addr  (urg_rd_addr),
		.norm_wr_en   (norm_wr_en),
		.norm_wr_addr (norm_wr_addr),
		.norm_rd_en   (norm_rd_en),
		.norm_rd_addr (norm_rd_addr),
		.flags        (flags),
		.count        (count)
	);

	tcpq_store #(.DEPTH(DEPTH)) u_urg_store (
		.clk     (clk),
		.wr_en   (urg_wr_en),
		.wr_addr (urg_wr_addr),
		.wr_data (payload),
		.rd_en   (urg_rd_en),
		.rd_addr (urg_rd_addr),
		.rd_data (urg_rd_data)
	);

	tcpq_store #(.DEPTH(DEPTH)) u_norm_store (
		.clk     (clk),
		.wr_en   (norm_wr_en),
		.wr_addr (norm_wr_addr),
		.wr_data (payload),
		.rd_en   (norm_rd_en),
		.rd_addr (norm_rd_addr),
		.rd_data (norm_rd_data)
	);

	always_comb begin
		out_payload = '0;
		if (flags.pop_valid) begin
			out_payload = flags.from_urgent ? urg_rd_data : norm_rd_data;
		end
	end

	assign accepted   = flags.accepted;
	assign pop_valid  = flags.pop_valid;
	assign out_urgent = flags.from_urgent;
	assign occupancy  = count;
	assign is_empty   = (count == '0);
	assign is_full    = (count == CNT_W'(DEPTH));

endmodule

// ===== rtl/tcpq_store.sv =====
// Ring storage for one priority class, with registered read data.
module tcpq_store #(
	parameter int DEPTH = tcpq_pkg::DEPTH_DEFAULT,
	localparam int PTR_W = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [PTR_W-1:0]           wr_addr,
	input  logic [tcpq_pkg::DATA_W-1:0] wr_data,
	input  logic                       rd_en,
	input  logic [PTR_W-1:0]           rd_addr,
	output logic [tcpq_pkg::DATA_W-1:0] rd_data
);

	logic [tcpq_pkg::DATA_W-1:0] mem [DEPTH];
	logic [tcpq_pkg::DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/tcpq_ctrl.sv =====
// Ring pointers, counts, push and pop decision and the result register.
module tcpq_ctrl #(
	parameter int DEPTH = tcpq_pkg::DEPTH_DEFAULT,
	localparam int PTR_W = $clog2(DEPTH),
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        operation,
	input  logic                        urgent,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        urg_wr_en,
	output logic [PTR_W-1:0]            urg_wr_addr,
	output logic                        urg_rd_en,
	output logic [PTR_W-1:0]            urg_rd_addr,
	output logic                        norm_wr_en,
	output logic [PTR_W-1:0]            norm_wr_addr,
	output logic                        norm_rd_en,
	output logic [PTR_W-1:0]            norm_rd_addr,
	output tcpq_pkg::result_flags_t     flags,
	output logic [CNT_W-1:0]            count
);

	logic [PTR_W-1:0] urg_head_q, urg_tail_q, norm_head_q, norm_tail_q;
	logic [CNT_W-1:0] urg_count_q, total_q;
	logic             valid_s1;
	tcpq_pkg::result_flags_t flags_s1, flags_d;
	logic             take;
	logic             do_push, do_pop, pop_urg;

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		ring_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign in_stall = valid_s1 && out_stall;
	assign take     = in_valid && !in_stall;

	always_comb begin
		do_push = 1'b0;
		do_pop  = 1'b0;
		unique case (tcpq_pkg::op_t'(operation))
			tcpq_pkg::OP_PUSH: do_push = take && (total_q != CNT_W'(DEPTH));
			tcpq_pkg::OP_POP:  do_pop  = take && (total_q != '0);
			default: ;
		endcase
	end

	assign pop_urg = urg_count_q != '0;

	assign urg_wr_en    = do_push && urgent;
	assign norm_wr_en   = do_push && !urgent;
	assign urg_rd_en    = do_pop && pop_urg;
	assign norm_rd_en   = do_pop && !pop_urg;
	assign urg_wr_addr  = urg_tail_q;
	assign norm_wr_addr = norm_tail_q;
	assign urg_rd_addr  = urg_head_q;
	assign norm_rd_addr = norm_head_q;

	always_comb begin
		flags_d.accepted    = do_push;
		flags_d.pop_valid   = do_pop;
		flags_d.from_urgent = do_pop && pop_urg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			urg_head_q  <= '0;
			urg_tail_q  <= '0;
			norm_head_q <= '0;
			norm_tail_q <= '0;
			urg_count_q <= '0;
			total_q     <= '0;
			valid_s1    <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (!out_stall) begin
				valid_s1 <= 1'b0;
			end
			if (urg_wr_en) begin
				urg_tail_q  <= ring_next(urg_tail_q);
				urg_count_q <= urg_count_q + CNT_W'(1);
			end
			if (norm_wr_en) begin
				norm_tail_q <= ring_next(norm_tail_q);
			end
			if (urg_rd_en) begin
				urg_head_q  <= ring_next(urg_head_q);
				urg_count_q <= urg_count_q - CNT_W'(1);
			end
			if (norm_rd_en) begin
				norm_head_q <= ring_next(norm_head_q);
			end
			if (do_push) begin
				total_q <= total_q + CNT_W'(1);
			end else if (do_pop) begin
				total_q <= total_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			flags_s1 <= flags_d;
		end
	end

	assign out_valid = valid_s1;
	assign flags     = flags_s1;
	assign count     = total_q;

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the two-class priority queue: directed and random traffic against a software queue.
`timescale 1ns / 100ps

module tb;

	localparam int DEPTH = tcpq_pkg::DEPTH_DEFAULT;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int RANDOM_ITEMS = 700;
	localparam int HOLD_CYCLES = 120;
	localparam int CYCLE_LIMIT = 300000;

	typedef struct {
		tcpq_pkg::op_t                kind;
		logic                         urg;
		logic [tcpq_pkg::DATA_W-1:0]  data;
	} request_t;

	typedef struct packed {
		tcpq_pkg::result_flags_t      flags;
		logic [tcpq_pkg::DATA_W-1:0]  data;
		logic [CNT_W-1:0]             level;
		logic                         empty;
		logic                         full;
	} reply_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic                          operation = 1'b0;
	logic                          urgent = 1'b0;
	logic [tcpq_pkg::DATA_W-1:0]   payload = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic                          accepted;
	logic                          pop_valid;
	logic                          out_urgent;
	logic [tcpq_pkg::DATA_W-1:0]   out_payload;
	logic [CNT_W-1:0]              occupancy;
	logic                          is_empty;
	logic                          is_full;

	two_class_priority_queue_top #(.DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.urgent(urgent),
		.payload(payload),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.accepted(accepted),
		.pop_valid(pop_valid),
		.out_urgent(out_urgent),
		.out_payload(out_payload),
		.occupancy(occupancy),
		.is_empty(is_empty),
		.is_full(is_full)
	);

	request_t request_backlog[$];
	reply_t   pending_replies[$];

	logic [tcpq_pkg::DATA_W-1:0] urgent_ring [DEPTH];
	logic [tcpq_pkg::DATA_W-1:0] normal_ring [DEPTH];
	logic [PTR_W-1:0]  urg_head = '0, urg_tail = '0, nrm_head = '0, nrm_tail = '0;
	int                urg_held = 0, total_held = 0;

	int mismatches = 0;
	int pushes_stored = 0, pushes_refused = 0, pops_served = 0, pops_empty = 0;
	int urgent_served = 0, full_hits = 0;
	int cycle_no = 0;
	int hold_at = 32'h7fffffff;
	logic hold_off = 1'b0;
	logic calm = 1'b0;
	int calm_left = 0;
	int tx_gap = 0, rx_gap = 0;

	always #5 clk = ~clk;

	function automatic logic [PTR_W-1:0] ring_step(logic [PTR_W-1:0] idx);
		return (idx == PTR_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
	endfunction

	function automatic reply_t apply_request(tcpq_pkg::op_t kind, logic urg,
			logic [tcpq_pkg::DATA_W-1:0] data);
		reply_t r;
		r = '0;
		if (kind == tcpq_pkg::OP_PUSH) begin
			if (total_held < DEPTH) begin
				if (urg) begin
					urgent_ring[urg_tail] = data;
					urg_tail = ring_step(urg_tail);
					urg_held++;
				end else begin
					normal_ring[nrm_tail] = data;
					nrm_tail = ring_step(nrm_tail);
				end
				total_held++;
				r.flags.accepted = 1'b1;
				pushes_stored++;
				if (total_held == DEPTH)
					full_hits++;
			end else
				pushes_refused++;
		end else if (total_held != 0) begin
			if (urg_held != 0) begin
				r.data = urgent_ring[urg_head];
				urg_head = ring_step(urg_head);
				urg_held--;
				r.flags.from_urgent = 1'b1;
				urgent_served++;
			end else begin
				r.data = normal_ring[nrm_head];
				nrm_head = ring_step(nrm_head);
			end
			total_held--;
			r.flags.pop_valid = 1'b1;
			pops_served++;
		end else
			pops_empty++;
		r.level = CNT_W'(total_held);
		r.empty = (total_held == 0);
		r.full = (total_held == DEPTH);
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 10);
		return $urandom_range(15, 40);
	endfunction

	task automatic queue_request(tcpq_pkg::op_t kind, logic urg,
			logic [tcpq_pkg::DATA_W-1:0] data);
		request_t q;
		q.kind = kind;
		q.urg = urg;
		q.data = data;
		request_backlog.push_back(q);
	endtask

	task automatic check_field(string name, logic [tcpq_pkg::DATA_W-1:0] want,
			logic [tcpq_pkg::DATA_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic wait_idle();
		while (request_backlog.size() != 0 || in_valid || pending_replies.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if (cycle_no > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_no);
			$display("tb NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (calm_left == 0) begin
			calm <= !calm;
			calm_left <= calm ? $urandom_range(100, 400) : $urandom_range(30, 80);
		end else
			calm_left <= calm_left - 1;
	end

	always @(posedge clk)
		hold_off <= (cycle_no >= hold_at) && (cycle_no < hold_at + HOLD_CYCLES);

	always @(posedge clk or negedge arst_n) begin
		request_t req;
		logic     took;
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_gap <= 0;
		end else begin
			took = in_valid && !in_stall;
			if (took)
				pending_replies.push_back(apply_request(tcpq_pkg::op_t'(operation),
					urgent, payload));
			if (!in_valid || took) begin
				if (tx_gap > 0) begin
					tx_gap <= tx_gap - 1;
					in_valid <= 1'b0;
				end else if (request_backlog.size() != 0) begin
					req = request_backlog.pop_front();
					in_valid <= 1'b1;
					operation <= req.kind;
					urgent <= req.urg;
					payload <= req.data;
					tx_gap <= calm ? 0 : pick_gap();
				end else
					in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_gap <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_replies.size() == 0) begin
					$display("%0t: result transfer with nothing expected", $time);
					mismatches++;
				end else begin
					want = pending_replies.pop_front();
					check_field("accepted", want.flags.accepted, accepted);
					check_field("pop_valid", want.flags.pop_valid, pop_valid);
					check_field("out_urgent", want.flags.from_urgent, out_urgent);
					check_field("out_payload", want.data, out_payload);
					check_field("occupancy", want.level, occupancy);
					check_field("is_empty", want.empty, is_empty);
					check_field("is_full", want.full, is_full);
				end
			end
			if (rx_gap > 0) begin
				rx_gap <= rx_gap - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= hold_off;
				rx_gap <= calm ? 0 : pick_gap();
			end
		end
	end

	initial begin
		int        sent;
		int        seg_len;
		int        push_pct;
		logic [tcpq_pkg::DATA_W-1:0] pattern;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// empty pop, fill to capacity, refused pushes, then drain four
		queue_request(tcpq_pkg::OP_POP, 1'b1, '1);
		for (int i = 0; i < DEPTH; i++) begin
			case (i)
				0: pattern = '0;
				1: pattern = '1;
				2: pattern = 24'hAAAAAA;
				3: pattern = 24'h555555;
				default: pattern = tcpq_pkg::DATA_W'(1) << (i + 4);
			endcase
			queue_request(tcpq_pkg::OP_PUSH, (i % 3) == 0, pattern);
		end
		queue_request(tcpq_pkg::OP_PUSH, 1'b1, 24'h123456);
		queue_request(tcpq_pkg::OP_PUSH, 1'b0, 24'h654321);
		repeat (4)
			queue_request(tcpq_pkg::OP_POP, 1'b0, '0);
		wait_idle();

		for (int half = 0; half < 2; half++) begin
			sent = 0;
			if (half == 0)
				hold_at = cycle_no + 40;
			while (sent < RANDOM_ITEMS / 2) begin
				seg_len = $urandom_range(10, 60);
				case ($urandom_range(0, 2))
					0: push_pct = 85;
					1: push_pct = 50;
					default: push_pct = 15;
				endcase
				for (int k = 0; k < seg_len; k++)
					queue_request(($urandom_range(0, 99) < push_pct) ?
						tcpq_pkg::OP_PUSH : tcpq_pkg::OP_POP,
						1'($urandom_range(0, 1)), tcpq_pkg::DATA_W'($urandom()));
				sent += seg_len;
			end
			// hold the sender until every outstanding result has arrived
			wait_idle();
		end

		repeat (8) @(posedge clk);
		$display("Pushes stored %0d, refused when full %0d, queue full %0d times",
			pushes_stored, pushes_refused, full_hits);
		$display("Pops served %0d (urgent %0d), pops on empty %0d",
			pops_served, urgent_served, pops_empty);
		if (mismatches == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
